>>> design/csq_pkg.sv
// Shared types and constants for the counting semaphore with a priority wait queue.
// No dependencies; imported by csq_wait_queue and counting_semaphore_priority_queue.
`default_nettype none

package csq_pkg;

    // Fixed field widths
    localparam int COUNT_BITS     = 8;
    localparam int STATUS_BITS    = 3;
    localparam int CFG_INDEX_BITS = 2;

    // Command codes
    localparam logic CMD_WAIT   = 1'b0;
    localparam logic CMD_SIGNAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_LIMIT   = 2'd1;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_QUEUE_FULL = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_RAISED     = 3'd4,
        ST_AT_MAX     = 3'd5
    } t_status;

    // Request from the semaphore control to the wait queue
    typedef struct packed {
        logic insert;
        logic remove;
    } t_q_req;

    // Response from the wait queue
    typedef struct packed {
        logic done;
    } t_q_rsp;

endpackage

`default_nettype wire

>>> design/csq_wait_queue.sv
// Priority-ordered wait queue: circular buffer in a memory, sorted insert by a tail walk.
// Depends on csq_pkg (request/response types).
`default_nettype none

module csq_wait_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_BITS  = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_q_req                             i_req,
    input  wire logic [TASK_ID_BITS-1:0]            i_task_id,
    input  wire logic [PRIORITY_BITS-1:0]           i_task_priority,
    output t_q_rsp                                  o_rsp,
    output logic      [TASK_ID_BITS-1:0]            o_woken_id,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   o_total
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        Q_IDLE     = 6'b000001,
        Q_READ     = 6'b000010,
        Q_CMP      = 6'b000100,
        Q_PLACE    = 6'b001000,
        Q_DEQ_READ = 6'b010000,
        Q_DEQ_OUT  = 6'b100000
    } t_q_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Queue storage
    logic [TASK_ID_BITS-1:0]  mem_id   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] mem_prio [QUEUE_DEPTH];

    t_q_state                 r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [AW-1:0]            r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]            r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]            r_left, n_left;
    logic [CW-1:0]            r_total, n_total;
    logic [TASK_ID_BITS-1:0]  r_id;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [TASK_ID_BITS-1:0]  r_rd_id;
    logic [PRIORITY_BITS-1:0] r_rd_prio;

    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [TASK_ID_BITS-1:0]  wr_id;
    logic [PRIORITY_BITS-1:0] wr_prio;
    logic                     done;

    // Read one entry per cycle; during the walk prefetch the next lower slot
    assign rd_addr = (r_state == Q_CMP) ? ptr_dec(r_rd_ptr) : r_rd_ptr;

    // Sequencer for insert walk and head removal
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_left   = r_left;
        n_total  = r_total;
        wr_en    = 1'b0;
        wr_addr  = r_wr_ptr;
        wr_id    = r_id;
        wr_prio  = r_prio;
        done     = 1'b0;
        case (r_state)
            Q_IDLE: begin
                if (i_req.insert) begin
                    n_total  = r_total + 1'b1;
                    n_tail   = ptr_inc(r_tail);
                    n_wr_ptr = r_tail;
                    n_rd_ptr = ptr_dec(r_tail);
                    n_left   = r_total;
                    n_state  = (r_total == '0) ? Q_PLACE : Q_READ;
                end else if (i_req.remove) begin
                    n_total  = r_total - 1'b1;
                    n_head   = ptr_inc(r_head);
                    n_rd_ptr = r_head;
                    n_state  = Q_DEQ_READ;
                end
            end
            Q_READ: begin
                n_state = Q_CMP;
            end
            Q_CMP: begin
                if (r_prio < r_rd_prio) begin
                    // shift the entry up one slot and keep walking toward the head
                    wr_en    = 1'b1;
                    wr_id    = r_rd_id;
                    wr_prio  = r_rd_prio;
                    n_wr_ptr = r_rd_ptr;
                    n_rd_ptr = ptr_dec(r_rd_ptr);
                    n_left   = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = Q_PLACE;
                    end
                end else begin
                    // equal or better entry found: new task goes behind it
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_state = Q_IDLE;
                end
            end
            Q_PLACE: begin
                wr_en   = 1'b1;
                done    = 1'b1;
                n_state = Q_IDLE;
            end
            Q_DEQ_READ: begin
                n_state = Q_DEQ_OUT;
            end
            Q_DEQ_OUT: begin
                done    = 1'b1;
                n_state = Q_IDLE;
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_total <= n_total;
        end
    end

    // Walk pointers and the task being inserted
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_left   <= n_left;
        if (r_state == Q_IDLE && i_req.insert) begin
            r_id   <= i_task_id;
            r_prio <= i_task_priority;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_id[wr_addr]   <= wr_id;
            mem_prio[wr_addr] <= wr_prio;
        end
        r_rd_id   <= mem_id[rd_addr];
        r_rd_prio <= mem_prio[rd_addr];
    end

    assign o_rsp.done = done;
    assign o_woken_id = r_rd_id;
    assign o_total    = r_total;

endmodule

`default_nettype wire

>>> design/counting_semaphore_priority_queue.sv
// Counting semaphore with a priority wait queue (top level).
// Acquire, raise, at-max and queue-full words are registered and show in the cycle after start;
// release waits on the dequeue, queueing on the one-slot-per-cycle insert walk in the memory.
// Throughput: one immediate word per cycle; busy holds off start while the queue works, and
// the next word is taken in the cycle the result shows. The receiver cannot stall.
// Reset clears the count to 0, the count limit to 1 and empties the queue; no clearing pass.
`default_nettype none

module counting_semaphore_priority_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_BITS  = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_command,
    input  wire logic [TASK_ID_BITS-1:0]            i_task_id,
    input  wire logic [PRIORITY_BITS-1:0]           i_task_priority,
    input  wire logic                               i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]          i_cfg_index,
    input  wire logic [COUNT_BITS-1:0]              i_cfg_data,
    output logic                                    o_valid,
    output logic      [STATUS_BITS-1:0]             o_status,
    output logic      [TASK_ID_BITS-1:0]            o_woken_task_id,
    output logic                                    o_reschedule,
    output logic      [COUNT_BITS-1:0]              o_count_now,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   o_waiters_now
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                    r_busy;
    logic [COUNT_BITS-1:0]   r_sem_count, n_sem_count;
    logic [COUNT_BITS-1:0]   r_count_limit;
    t_status                 r_pend_status;
    logic                    r_valid;
    t_status                 r_status;
    logic [TASK_ID_BITS-1:0] r_woken;
    logic                    r_resched;
    logic [COUNT_BITS-1:0]   r_count_now;
    logic [CW-1:0]           r_waiters_now;

    logic                    accept;
    t_q_req                  q_req;
    t_q_rsp                  q_rsp;
    logic [TASK_ID_BITS-1:0] q_woken;
    logic [CW-1:0]           q_total;
    t_status                 dec_status;

    assign accept = start && !r_busy;

    // Decide the outcome of a command against the current count and queue fill
    always_comb begin
        n_sem_count  = r_sem_count;
        q_req.insert = 1'b0;
        q_req.remove = 1'b0;
        dec_status   = ST_ACQUIRED;
        if (i_command == CMD_WAIT) begin
            if (r_sem_count != '0) begin
                n_sem_count = r_sem_count - 1'b1;
                dec_status  = ST_ACQUIRED;
            end else if (q_total >= CW'(QUEUE_DEPTH)) begin
                dec_status = ST_QUEUE_FULL;
            end else begin
                q_req.insert = accept;
                dec_status   = ST_QUEUED;
            end
        end else begin
            if (q_total != '0) begin
                q_req.remove = accept;
                dec_status   = ST_RELEASED;
            end else if (r_sem_count < r_count_limit) begin
                n_sem_count = r_sem_count + 1'b1;
                dec_status  = ST_RAISED;
            end else begin
                dec_status = ST_AT_MAX;
            end
        end
    end

    csq_wait_queue #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TASK_ID_BITS  (TASK_ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (q_req),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .o_rsp           (q_rsp),
        .o_woken_id      (q_woken),
        .o_total         (q_total)
    );

    // Control state: busy flag, count, limit, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_sem_count   <= '0;
            r_count_limit <= COUNT_BITS'(1);
            r_valid       <= 1'b0;
        end else begin
            // Strobe an immediate outcome or the end of a queue operation
            r_valid <= (accept && !(q_req.insert || q_req.remove)) || (r_busy && q_rsp.done);
            if (accept && (q_req.insert || q_req.remove)) begin
                r_busy <= 1'b1;
            end else if (r_busy && q_rsp.done) begin
                r_busy <= 1'b0;
            end
            // Load the count from a configuration write, else advance it on a command
            if (i_cfg_we && i_cfg_index == CFG_INITIAL_COUNT) begin
                r_sem_count <= i_cfg_data;
            end else if (accept) begin
                r_sem_count <= n_sem_count;
            end
            if (i_cfg_we && i_cfg_index == CFG_COUNT_LIMIT) begin
                r_count_limit <= i_cfg_data;
            end
        end
    end

    // Result word: immediate outcome, or queue outcome at completion
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status <= dec_status;
            if (!(q_req.insert || q_req.remove)) begin
                r_status      <= dec_status;
                r_woken       <= '0;
                r_resched     <= (dec_status == ST_QUEUE_FULL);
                r_count_now   <= n_sem_count;
                r_waiters_now <= q_total;
            end
        end
        if (r_busy && q_rsp.done) begin
            r_status      <= r_pend_status;
            r_woken       <= (r_pend_status == ST_RELEASED) ? q_woken : '0;
            r_resched     <= 1'b1;
            r_count_now   <= r_sem_count;
            r_waiters_now <= q_total;
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_woken_task_id = r_woken;
    assign o_reschedule    = r_resched;
    assign o_count_now     = r_count_now;
    assign o_waiters_now   = r_waiters_now;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for counting_semaphore_priority_queue: directed and random waits and
// signals against a built-in prediction of count, priority wait queue and result words.
// Depends on csq_pkg and the design top level only.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csq_pkg::*;

    localparam int QD            = 16;
    localparam int ID_W          = 8;
    localparam int PRIO_W        = 8;
    localparam int WAIT_W        = $clog2(QD + 1);
    localparam int SETTLE_CYCLES = QD + 4;
    localparam int MAX_REPORTS   = 10;

    // Indexes with no register behind them: writes there must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        t_status               status;
        logic [ID_W-1:0]       woken_id;
        logic                  reschedule;
        logic [COUNT_BITS-1:0] count;
        logic [WAIT_W-1:0]     waiters;
    } t_sem_result;

    // Semaphore state tracker and result word checker
    class t_outcome_board;
        logic [COUNT_BITS-1:0] initial_reg;
        logic [COUNT_BITS-1:0] max_reg;
        logic [COUNT_BITS-1:0] sem_count;
        int                    waiting;
        logic [ID_W-1:0]       q_id[QD];
        logic [PRIO_W-1:0]     q_prio[QD];
        t_sem_result           outcomes_due[$];
        int                    errors;

        function new();
            initial_reg = '0;
            max_reg     = COUNT_BITS'(1);
            sem_count   = '0;
            waiting     = 0;
            errors      = 0;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] data);
            if (idx == CFG_INITIAL_COUNT) begin
                initial_reg = data;
                sem_count   = data;
            end else if (idx == CFG_COUNT_LIMIT) begin
                max_reg = data;
            end
        endfunction

        // Predict the result word of one accepted command and queue it
        function void note_command(logic cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
            t_sem_result r;
            int          pos;
            bit          found;
            r = '0;
            if (cmd == CMD_WAIT) begin
                if (sem_count > 0) begin
                    sem_count--;
                    r.status = ST_ACQUIRED;
                end else begin
                    r.reschedule = 1'b1;
                    if (waiting >= QD) begin
                        r.status = ST_QUEUE_FULL;
                    end else begin
                        // insert behind every entry of equal or better priority
                        pos   = waiting;
                        found = 1'b0;
                        for (int i = 0; i < QD; i++)
                            if (!found && i < waiting && prio < q_prio[i]) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        for (int i = QD - 1; i > 0; i--)
                            if (i <= waiting && i > pos) begin
                                q_id[i]   = q_id[i-1];
                                q_prio[i] = q_prio[i-1];
                            end
                        q_id[pos]   = id;
                        q_prio[pos] = prio;
                        waiting++;
                        r.status = ST_QUEUED;
                    end
                end
            end else begin
                if (waiting > 0) begin
                    // pop the head and shift the rest forward
                    r.woken_id   = q_id[0];
                    r.reschedule = 1'b1;
                    r.status     = ST_RELEASED;
                    for (int i = 0; i < QD - 1; i++)
                        if (i + 1 < waiting) begin
                            q_id[i]   = q_id[i+1];
                            q_prio[i] = q_prio[i+1];
                        end
                    waiting--;
                end else if (sem_count < max_reg) begin
                    sem_count++;
                    r.status = ST_RAISED;
                end else begin
                    r.status = ST_AT_MAX;
                end
            end
            r.count   = sem_count;
            r.waiters = WAIT_W'(waiting);
            outcomes_due.push_back(r);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_outcome(t_sem_result got);
            t_sem_result want;
            if (outcomes_due.size() == 0) begin
                report($sformatf("result word with nothing expected, status %0d", got.status));
                return;
            end
            want = outcomes_due.pop_front();
            if (got.status !== want.status || got.woken_id !== want.woken_id ||
                got.reschedule !== want.reschedule || got.count !== want.count ||
                got.waiters !== want.waiters)
                report($sformatf({"status exp %0d got %0d, woken exp %0h got %0h, ",
                                  "resched exp %0b got %0b, count exp %0d got %0d, ",
                                  "waiters exp %0d got %0d"},
                                 want.status, got.status, want.woken_id, got.woken_id,
                                 want.reschedule, got.reschedule, want.count, got.count,
                                 want.waiters, got.waiters));
        endfunction
    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      start           = 1'b0;
    logic                      busy;
    logic                      i_command       = CMD_WAIT;
    logic [ID_W-1:0]           i_task_id       = '0;
    logic [PRIO_W-1:0]         i_task_priority = '0;
    logic                      i_cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index     = CFG_INITIAL_COUNT;
    logic [COUNT_BITS-1:0]     i_cfg_data      = '0;
    logic                      o_valid;
    logic [STATUS_BITS-1:0]    o_status;
    logic [ID_W-1:0]           o_woken_task_id;
    logic                      o_reschedule;
    logic [COUNT_BITS-1:0]     o_count_now;
    logic [WAIT_W-1:0]         o_waiters_now;

    t_outcome_board board;
    t_sem_result    seen;
    bit             quiet = 1'b0;

    counting_semaphore_priority_queue #(
        .QUEUE_DEPTH   (QD),
        .TASK_ID_BITS  (ID_W),
        .PRIORITY_BITS (PRIO_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_woken_task_id (o_woken_task_id),
        .o_reschedule    (o_reschedule),
        .o_count_now     (o_count_now),
        .o_waiters_now   (o_waiters_now)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Sample both handshakes at the edge: check the result word, then note the new command
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                seen.status     = t_status'(o_status);
                seen.woken_id   = o_woken_task_id;
                seen.reschedule = o_reschedule;
                seen.count      = o_count_now;
                seen.waiters    = o_waiters_now;
                board.check_outcome(seen);
            end
            if (start && !busy)
                board.note_command(i_command, i_task_id, i_task_priority);
        end
    end

    // Present one command word after a random gap and hold it until taken
    task automatic send_command(input logic cmd, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, 6));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_task_id       <= id;
        i_task_priority <= prio;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and let every expected word arrive, then let the queue settle
    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then drop the enable for a cycle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COUNT_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random words in bursts: fill-heavy, drain-heavy or balanced, with narrow or wide priorities
    task automatic run_random(input int n);
        int                pct;
        bit                narrow;
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        pct    = 50;
        narrow = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0: pct = 85;
                    1: pct = 15;
                    default: pct = 50;
                endcase
                narrow = 1'($urandom_range(0, 1));
                quiet  = ($urandom_range(0, 3) == 0);
            end
            cmd  = ($urandom_range(0, 99) < pct) ? CMD_WAIT : CMD_SIGNAL;
            id   = ID_W'($urandom);
            prio = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            send_command(cmd, id, prio);
        end
        quiet = 1'b0;
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unused indexes change nothing; a count loaded above the limit holds on signal
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'hFF);
        write_reg(CFG_INITIAL_COUNT, 8'hFF);
        send_command(CMD_SIGNAL, 8'h00, 8'h00);
        send_command(CMD_WAIT, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_INITIAL_COUNT, 8'h00);

        // Raise to the limit, hold there, acquire back to zero
        send_command(CMD_SIGNAL, 8'hFF, 8'hFF);
        send_command(CMD_SIGNAL, 8'h00, 8'h00);
        send_command(CMD_WAIT, 8'h00, 8'h00);

        // Fill the queue: priority extremes, equal priorities in arrival order
        send_command(CMD_WAIT, 8'hFF, 8'hFF);
        send_command(CMD_WAIT, 8'h00, 8'h00);
        send_command(CMD_WAIT, 8'hA5, 8'hFF);
        send_command(CMD_WAIT, 8'h5A, 8'h80);
        send_command(CMD_WAIT, 8'h11, 8'h80);
        for (int k = 0; k < QD - 5; k++)
            send_command(CMD_WAIT, ID_W'($urandom), PRIO_W'($urandom));
        // Queue full drops the word; then release the head
        send_command(CMD_WAIT, 8'h3C, 8'h00);
        send_command(CMD_SIGNAL, 8'h00, 8'h00);
        wait_idle();

        // Random phases across register settings, extremes included
        write_reg(CFG_COUNT_LIMIT, 8'hFF);
        run_random(64);
        wait_idle();
        write_reg(CFG_INITIAL_COUNT, 8'hFF);
        run_random(64);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 8'h00);
        write_reg(CFG_INITIAL_COUNT, 8'h00);
        run_random(64);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 8'd5);
        write_reg(CFG_INITIAL_COUNT, 8'd3);
        run_random(64);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, COUNT_BITS'($urandom));
        write_reg(CFG_INITIAL_COUNT, COUNT_BITS'($urandom));
        run_random(64);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 8'd1);
        write_reg(CFG_INITIAL_COUNT, 8'd1);
        run_random(64);

        wait_idle();
        if (board.pending() != 0)
            board.report("result words still expected at end of run");
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Bound the run well beyond the slowest legal completion
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
